>>> rtl/assert_macros.svh
// Assertion macros shared by the heap priority queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MHPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define MHPQ_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/mhpq_pkg.sv
// Types and constants of the heap priority queue.
package mhpq_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_PEEK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT,
    S_LAST,
    S_DN_START,
    S_DN_R,
    S_DN_CMP,
    S_UP_CMP,
    S_SCAN,
    S_RM_LAST,
    S_WR_FIN,
    S_DONE
  } mhpq_state_t;

  typedef struct packed {
    action_t           action;
    logic [ID_W-1:0]   item_id;
    logic [KEY_W-1:0]  item_key;
  } mhpq_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   result_id;
    logic [KEY_W-1:0]  result_key;
    status_t           status;
    logic [CNT_W-1:0]  entry_count;
  } mhpq_result_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ID_W-1:0]   id;
  } heap_entry_t;

endpackage

>>> rtl/mhpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mhpq_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/min_heap_priority_queue_unit.sv
// Binary min-heap priority queue: sequencer, shared key comparator and heap RAM.
//
// Usage: present a command on cmd and raise start; the transaction is taken at a
// rising edge where start is high and busy is low. busy stays high until the
// result has been shown. The result appears on result for exactly one cycle,
// marked by done; the receiver cannot stall it, so capture it on that edge.
// Commands: push (key, id), pop minimum, remove by id, peek minimum. Every
// command returns one result with status (ok, empty, full, id not found) and
// the entry count after the command; id and key are zero unless popped/peeked.
//
// Sequence per transaction, accepting cycle through done cycle (the next one can be
// accepted right after done); an entry moves at most log2 of capacity levels:
//   peek reads the root; push compares with one parent per level, or writes an empty heap directly.
//   pop with one entry just returns it, else it moves the last entry to the root and sifts it down
//   (left read, right read, compare per level).
//   remove scans from slot 0 for the id; unless the match is the last entry, it moves the last
//   entry into the matched slot and sifts it up or down; on a miss it scans every entry.
// The one-read, one-write heap RAM and the single key comparator set this sequencing.
// After reset the heap is empty; slot contents are never read before written.
module min_heap_priority_queue_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  mhpq_pkg::mhpq_cmd_t   cmd,
  output logic                  busy,
  output logic                  done,
  output mhpq_pkg::mhpq_result_t result
);
  import mhpq_pkg::*;

  localparam int unsigned CH_W = IDX_W + 1;

  mhpq_state_t      state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] pos;
  action_t          act;
  heap_entry_t      mov;
  heap_entry_t      left;
  logic             lsel;
  logic [KEY_W-1:0] bkey;
  logic             try_down;
  logic [ID_W-1:0]  res_id;
  logic [KEY_W-1:0] res_key;
  status_t          res_stat;

  // heap RAM port
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  heap_entry_t      wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [$bits(heap_entry_t)-1:0] rd_raw;
  heap_entry_t      rd_ent;

  // shared key comparator
  logic [KEY_W-1:0] cmp_a, cmp_b;
  logic             lt;

  // index arithmetic
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] pos_m1, par, par_m1, ppar;
  logic [IDX_W-1:0] cnt_idx, cnt_idx_m1, push_par;
  logic [CH_W-1:0]  lch;
  logic [IDX_W-1:0] rch;
  logic             l_in, r_in;
  logic             take_r, moved, match, at_last, full;

  mhpq_ram #(
    .WIDTH($bits(heap_entry_t)),
    .DEPTH(CAPACITY)
  ) u_heap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_ent     = heap_entry_t'(rd_raw);
  assign lt         = cmp_a < cmp_b;

  assign cnt_m1     = cnt - CNT_W'(1);
  assign pos_m1     = pos - IDX_W'(1);
  assign par        = pos_m1 >> 1;
  assign par_m1     = par - IDX_W'(1);
  assign ppar       = par_m1 >> 1;
  assign cnt_idx    = cnt[IDX_W-1:0];
  assign cnt_idx_m1 = cnt_idx - IDX_W'(1);
  assign push_par   = cnt_idx_m1 >> 1;
  assign lch        = {pos, 1'b1};
  assign rch        = lch[IDX_W-1:0] + IDX_W'(1);
  // sift down runs only with at least one entry held
  assign l_in       = lch < CH_W'(cnt);
  assign r_in       = lch < CH_W'(cnt_m1);
  assign take_r     = r_in && lt;
  assign moved      = take_r || lsel;
  assign match      = rd_ent.id == mov.id;
  assign at_last    = CNT_W'(pos) == cnt_m1;
  assign full       = cnt == CNT_W'(CAPACITY);

  // Next state and fill count.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (cmd.action)
            ACT_PUSH: begin
              if (full) begin
                state_next = S_DONE;
              end else begin
                cnt_next   = cnt + CNT_W'(1);
                state_next = (cnt == '0) ? S_DONE : S_UP_CMP;
              end
            end
            ACT_POP, ACT_PEEK: begin
              state_next = (cnt == '0) ? S_DONE : S_ROOT;
            end
            ACT_REMOVE: begin
              state_next = (cnt == '0) ? S_DONE : S_SCAN;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_ROOT: begin
        if (act == ACT_POP) begin
          cnt_next   = cnt_m1;
          state_next = (cnt_m1 == '0) ? S_DONE : S_LAST;
        end else begin
          state_next = S_DONE;
        end
      end
      S_LAST:     state_next = S_DN_START;
      S_DN_START: state_next = l_in ? S_DN_R : S_DONE;
      S_DN_R:     state_next = S_DN_CMP;
      S_DN_CMP:   state_next = moved ? S_DN_START : S_DONE;
      S_UP_CMP: begin
        if (lt) begin
          state_next = (par == '0) ? S_WR_FIN : S_UP_CMP;
        end else begin
          state_next = try_down ? S_DN_START : S_DONE;
        end
      end
      S_SCAN: begin
        if (match) begin
          cnt_next   = cnt_m1;
          state_next = at_last ? S_DONE : S_RM_LAST;
        end else if (at_last) begin
          state_next = S_DONE;
        end
      end
      S_RM_LAST:  state_next = (pos == '0) ? S_DN_START : S_UP_CMP;
      S_WR_FIN:   state_next = S_DONE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // RAM port and comparator operands.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = mov;
    rd_addr = pos;
    cmp_a   = rd_ent.key;
    cmp_b   = mov.key;
    case (state)
      S_IDLE: begin
        wr_addr = '0;
        wr_data = '{key: cmd.item_key, id: cmd.item_id};
        wr_en   = start && (cmd.action == ACT_PUSH) && (cnt == '0);
        rd_addr = (cmd.action == ACT_PUSH) ? push_par : '0;
      end
      S_ROOT:     rd_addr = cnt_m1[IDX_W-1:0];
      S_DN_START: begin
        rd_addr = lch[IDX_W-1:0];
        wr_en   = !l_in;
      end
      S_DN_R:     rd_addr = rch;
      S_DN_CMP: begin
        cmp_b   = bkey;
        wr_en   = 1'b1;
        wr_data = take_r ? rd_ent : (lsel ? left : mov);
      end
      S_UP_CMP: begin
        cmp_a   = mov.key;
        cmp_b   = rd_ent.key;
        rd_addr = ppar;
        wr_en   = lt || !try_down;
        wr_data = lt ? rd_ent : mov;
      end
      S_SCAN:     rd_addr = match ? cnt_m1[IDX_W-1:0] : pos + IDX_W'(1);
      S_RM_LAST:  rd_addr = par;
      S_WR_FIN:   wr_en = 1'b1;
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          act      <= cmd.action;
          mov      <= '{key: cmd.item_key, id: cmd.item_id};
          pos      <= (cmd.action == ACT_PUSH) ? cnt_idx : '0;
          try_down <= 1'b0;
          res_id   <= '0;
          res_key  <= '0;
          case (cmd.action)
            ACT_PUSH:          res_stat <= full ? STAT_FULL : STAT_OK;
            ACT_POP, ACT_PEEK: res_stat <= (cnt == '0) ? STAT_EMPTY : STAT_OK;
            ACT_REMOVE:        res_stat <= (cnt == '0) ? STAT_NOTFOUND : STAT_OK;
            default:           res_stat <= STAT_OK;
          endcase
        end
      end
      S_ROOT: begin
        res_id  <= rd_ent.id;
        res_key <= rd_ent.key;
      end
      S_LAST: mov <= rd_ent;
      S_DN_R: begin
        left <= rd_ent;
        lsel <= lt;
        bkey <= lt ? rd_ent.key : mov.key;
      end
      S_DN_CMP: begin
        if (take_r) begin
          pos <= rch;
        end else if (lsel) begin
          pos <= lch[IDX_W-1:0];
        end
      end
      S_UP_CMP: begin
        if (lt) begin
          pos <= par;
        end
        try_down <= 1'b0;
      end
      S_SCAN: begin
        if (!match) begin
          pos <= pos + IDX_W'(1);
          if (at_last) begin
            res_stat <= STAT_NOTFOUND;
          end
        end
      end
      S_RM_LAST: begin
        mov      <= rd_ent;
        try_down <= 1'b1;
      end
      default: begin
        lsel <= lsel;
      end
    endcase
  end

  // Result channel: shown for the single cycle spent in the done state.
  assign busy               = state != S_IDLE;
  assign done               = state == S_DONE;
  assign result.result_id   = res_id;
  assign result.result_key  = res_key;
  assign result.status      = res_stat;
  assign result.entry_count = cnt;

`include "assert_macros.svh"

  `MHPQ_ASSERT(a_launch, start && !busy |=> busy, "accepted transaction did not start work")
  `MHPQ_ASSERT(a_strobe, done |=> !done && !busy, "result strobe longer than one cycle")
  `MHPQ_ASSERT(a_cnt_hold, !busy && !start |=> $stable(cnt), "fill count moved while idle")
  `MHPQ_ASSERT(a_full_cnt, done && res_stat == STAT_FULL |-> full, "full status with room left")
  `MHPQ_NEVER(a_cnt_range, cnt > CNT_W'(CAPACITY), "fill count beyond capacity")

endmodule
